[rtl/core/bpeq_pkg.sv]
// Package with the shared types and codes of the bounded priority event queue.
`timescale 1ns / 1ps

package bpeq_pkg;

  // Field widths fixed by the interface.
  localparam int PRIO_W    = 8;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 2;
  localparam int FILL_W    = 5;
  localparam int CAP_W     = 5;
  localparam int CFG_IDX_W = 1;

  // Request codes.
  localparam logic REQ_SEND = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'd1;

  // Queue modes.
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_PRIO = 1'b1;

  // Reset value of the capacity register.
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;    // capture the accepted request
    logic compare;  // register the per-slot priority compares
    logic commit;   // update the queue and load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_take;   // captured request is a take
    logic prio_mode;  // queue is in priority mode
    logic out_free;   // output register can take a result this cycle
  } sts_t;

endpackage

[rtl/core/bpeq_ctrl.sv]
// Controller state machine that sequences one request at a time.
`timescale 1ns / 1ps

module bpeq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bpeq_pkg::sts_t sts,
  output bpeq_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_COMPARE = 2'd1;
  localparam logic [1:0] S_COMMIT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next  = state;
    cmd.latch   = 1'b0;
    cmd.compare = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        // Only a send in priority mode needs the compare results.
        if (!sts.req_take && sts.prio_mode) begin
          cmd.compare = 1'b1;
        end
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // Hold here while the previous result still waits for its transfer.
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The queue is updated only when the output register has room.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.out_free)
    else $error("commit issued while output register busy");

  // A request is always followed by its compare step.
  a_latch_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> state == S_COMPARE)
    else $error("accepted request did not proceed to compare");

  // The compare step always leads to commit.
  a_compare_seq: assert property (@(posedge clk) disable iff (rst)
    state == S_COMPARE |=> state == S_COMMIT)
    else $error("compare step not followed by commit");

endmodule

[rtl/core/bpeq_dpath.sv]
// Datapath: row of event slots, compare cells, config registers and output register.
`timescale 1ns / 1ps

module bpeq_dpath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bpeq_pkg::cmd_t                    cmd,
  output bpeq_pkg::sts_t                    sts,
  input  logic                              req_type,
  input  logic [bpeq_pkg::PRIO_W-1:0]       event_priority,
  input  logic [bpeq_pkg::PAYLOAD_W-1:0]    event_payload,
  input  logic                              cfg_write,
  input  logic [bpeq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpeq_pkg::CAP_W-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bpeq_pkg::STATUS_W-1:0]     status,
  output logic [bpeq_pkg::PRIO_W-1:0]       out_priority,
  output logic [bpeq_pkg::PAYLOAD_W-1:0]    out_payload,
  output logic [bpeq_pkg::FILL_W-1:0]       fill_level
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > bpeq_pkg::CAP_W) ? CNT_W : bpeq_pkg::CAP_W;
  localparam int LVL   = $clog2(QUEUE_DEPTH);

  // Slot storage, slot 0 is the head.
  logic [bpeq_pkg::PRIO_W-1:0]    slot_prio [QUEUE_DEPTH];
  logic [bpeq_pkg::PAYLOAD_W-1:0] slot_payload [QUEUE_DEPTH];
  logic [CNT_W-1:0]               count;

  // Configuration registers.
  logic                           queue_mode;
  logic [bpeq_pkg::CAP_W-1:0]     capacity;

  // Captured request.
  logic                           req_take;
  logic [bpeq_pkg::PRIO_W-1:0]    req_prio;
  logic [bpeq_pkg::PAYLOAD_W-1:0] req_payload;

  // Compare results and insertion decode.
  logic [QUEUE_DEPTH-1:0] gt_now;
  logic [QUEUE_DEPTH-1:0] gt_vec;
  logic [QUEUE_DEPTH-1:0] eff_gt;
  logic [QUEUE_DEPTH-1:0] incl;
  logic [QUEUE_DEPTH-1:0] shift_in;
  logic [QUEUE_DEPTH-1:0] put_here;
  logic                   any_gt;
  logic                   full;
  logic                   do_take;
  logic                   do_insert;

  assign sts.req_take  = req_take;
  assign sts.prio_mode = (queue_mode == bpeq_pkg::MODE_PRIO);
  assign sts.out_free  = !out_valid || out_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_mode <= bpeq_pkg::MODE_FIFO;
      capacity   <= bpeq_pkg::CAPACITY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bpeq_pkg::REG_QUEUE_MODE: queue_mode <= cfg_data[0];
        bpeq_pkg::REG_CAPACITY:   capacity   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request capture and compare register.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_take    <= (req_type == bpeq_pkg::REQ_TAKE);
      req_prio    <= event_priority;
      req_payload <= event_payload;
    end
    if (cmd.compare) begin
      gt_vec <= gt_now;
    end
  end

  // Full when the fill reaches the capacity or the physical depth.
  assign full = (CMP_W'(count) >= CMP_W'(capacity)) ||
                (count == CNT_W'(QUEUE_DEPTH));
  assign do_take   = req_take && (count != '0);
  assign do_insert = !req_take && !full;

  // In FIFO mode no compare hits, so the new event lands at the tail.
  assign eff_gt = sts.prio_mode ? gt_vec : '0;

  // Prefix OR of the hits marks the insertion point and the slots behind it.
  always_comb begin
    incl = eff_gt;
    for (int k = 0; k < LVL; k++) begin
      incl = incl | (incl << (1 << k));
    end
  end

  assign shift_in = incl << 1;
  assign any_gt   = incl[QUEUE_DEPTH-1];

  // One compare cell per slot.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [bpeq_pkg::PRIO_W-1:0]    prev_prio;
    logic [bpeq_pkg::PAYLOAD_W-1:0] prev_payload;
    logic [bpeq_pkg::PRIO_W-1:0]    next_prio;
    logic [bpeq_pkg::PAYLOAD_W-1:0] next_payload;

    if (g > 0) begin : g_prev
      assign prev_prio    = slot_prio[g-1];
      assign prev_payload = slot_payload[g-1];
    end else begin : g_noprev
      assign prev_prio    = slot_prio[g];
      assign prev_payload = slot_payload[g];
    end

    if (g < QUEUE_DEPTH - 1) begin : g_next
      assign next_prio    = slot_prio[g+1];
      assign next_payload = slot_payload[g+1];
    end else begin : g_nonext
      assign next_prio    = slot_prio[g];
      assign next_payload = slot_payload[g];
    end

    assign gt_now[g] = (CNT_W'(g) < count) && (req_prio > slot_prio[g]);

    // The first strictly lower slot, or the tail when none is lower.
    assign put_here[g] = (eff_gt[g] && !shift_in[g]) ||
                         (!any_gt && (count == CNT_W'(g)));

    always_ff @(posedge clk) begin
      if (cmd.commit && do_take) begin
        slot_prio[g]    <= next_prio;
        slot_payload[g] <= next_payload;
      end else if (cmd.commit && do_insert) begin
        if (shift_in[g]) begin
          slot_prio[g]    <= prev_prio;
          slot_payload[g] <= prev_payload;
        end else if (put_here[g]) begin
          slot_prio[g]    <= req_prio;
          slot_payload[g] <= req_payload;
        end
      end
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      if (do_take) begin
        count <= count - CNT_W'(1);
      end else if (do_insert) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Output register, one result per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_priority <= '0;
      out_payload  <= '0;
      status       <= bpeq_pkg::ST_OK;
      if (req_take) begin
        if (count == '0) begin
          status     <= bpeq_pkg::ST_EMPTY;
          fill_level <= bpeq_pkg::FILL_W'(count);
        end else begin
          out_priority <= slot_prio[0];
          out_payload  <= slot_payload[0];
          fill_level   <= bpeq_pkg::FILL_W'(count - CNT_W'(1));
        end
      end else if (full) begin
        status     <= bpeq_pkg::ST_FULL;
        fill_level <= bpeq_pkg::FILL_W'(count);
      end else begin
        fill_level <= bpeq_pkg::FILL_W'(count + CNT_W'(1));
      end
    end
  end

  // The fill count only moves on a commit.
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(count))
    else $error("fill count changed without a commit");

  // The reported fill matches the stored count after each commit.
  a_fill_match: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> fill_level == bpeq_pkg::FILL_W'(count))
    else $error("reported fill level differs from stored count");

  // The count never passes the physical depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

endmodule

[rtl/core/bounded_priority_event_queue_unit.sv]
// Top level of the bounded priority event queue.
//
//   channel   direction  handshake              fields
//   in        input      in_valid / in_ready    req_type, event_priority, event_payload
//   out       output     out_valid / out_ready  status, out_priority, out_payload, fill_level
//   cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each request passes through the compare step and then the commit step
// before the input is free again; only a priority-mode send registers the
// compare cell results in the compare step. One request is in flight at a time.
// The commit step waits while the output register still holds an untaken
// result. Reset clears the fill count, the mode (FIFO), the capacity (16)
// and the controller; slot contents are not cleared.
`timescale 1ns / 1ps

module bounded_priority_event_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [bpeq_pkg::PRIO_W-1:0]       event_priority,
  input  logic [bpeq_pkg::PAYLOAD_W-1:0]    event_payload,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bpeq_pkg::STATUS_W-1:0]     status,
  output logic [bpeq_pkg::PRIO_W-1:0]       out_priority,
  output logic [bpeq_pkg::PAYLOAD_W-1:0]    out_payload,
  output logic [bpeq_pkg::FILL_W-1:0]       fill_level,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpeq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpeq_pkg::CAP_W-1:0]        cfg_data
);

  bpeq_pkg::cmd_t cmd;
  bpeq_pkg::sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  bpeq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpeq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_type       (req_type),
    .event_priority (event_priority),
    .event_payload  (event_payload),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .out_priority   (out_priority),
    .out_payload    (out_payload),
    .fill_level     (fill_level)
  );

endmodule
